/* rtl/lrubc_pkg.sv */
// ----------------------------------------------------------------------------
// lrubc_pkg
// Shared types and codes of the LRU block buffer cache tag table.
// ----------------------------------------------------------------------------
package lrubc_pkg;

    // Command codes (slave tuser)
    localparam logic [1:0] CMD_ACQUIRE   = 2'd0;
    localparam logic [1:0] CMD_WRITEBACK = 2'd1;
    localparam logic [1:0] CMD_RELEASE   = 2'd2;
    localparam logic [1:0] CMD_SYNC_DONE = 2'd3;

    // Status codes (master tdata, low field)
    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_WAIT      = 3'd1;
    localparam logic [2:0] ST_NO_FREE   = 3'd2;
    localparam logic [2:0] ST_NOT_OWNED = 3'd3;
    localparam logic [2:0] ST_OK        = 3'd4;

    // Field widths
    localparam int DEV_W   = 8;
    localparam int SEC_W   = 32;
    localparam int TAG_W   = DEV_W + SEC_W;
    localparam int ENTRY_W = 4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DECIDE,
        S_RANK,
        S_HOLD
    } t_state;

endpackage

/* rtl/lru_block_buffer_cache.sv */
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// Fully associative tag table with LRU replacement for a block buffer cache.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per transfer: tuser is the command
//   (acquire, write back, release, sync done), tdata the block tag and the
//   entry index. Master channel returns exactly one result per command.
//   Acquire walks the tag and rank memories one entry per cycle through a
//   single tag/rank compare unit, then sweeps the rank memory once more to
//   make the chosen entry most recently used; an acquire that answers wait
//   or no free entry skips the rank sweep. Write back, release and sync
//   done touch only the flag registers. One command is in work at a time;
//   s_tready is high whenever the sequencer is idle, also while a result
//   still waits in the output register. After reset a clearing pass over
//   all entries loads the reset ranks; s_tready stays low until it ends.
//   A stalled master holds the result in the output register; a finished
//   command waits until that register frees.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache
    import lrubc_pkg::*;
#(
    parameter int ENTRY_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // device[7:0], sector[39:8], entry[43:40], zero fill
    input  logic [1:0]  i_s_tuser,  // cmd[1:0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // status[2:0], granted_entry[6:3], needs_fill[7],
                                    // needs_writeback[8], zero fill
);

    localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CW = $clog2(ENTRY_COUNT + 1);
    localparam logic [CW-1:0] CNT_END  = CW'(ENTRY_COUNT);
    localparam logic [CW-1:0] CNT_LAST = CW'(ENTRY_COUNT - 1);
    localparam logic [EW-1:0] RANK_TOP = EW'(ENTRY_COUNT - 1);

    // input unpack
    logic [1:0]         w_cmd;
    logic [DEV_W-1:0]   w_dev;
    logic [SEC_W-1:0]   w_sec;
    logic [ENTRY_W-1:0] w_entry;
    logic [EW-1:0]      w_idx;
    logic               w_in_range;
    logic               w_in_xfer;

    assign w_cmd      = i_s_tuser;
    assign w_dev      = i_s_tdata[7:0];
    assign w_sec      = i_s_tdata[39:8];
    assign w_entry    = i_s_tdata[43:40];
    assign w_idx      = EW'(w_entry);
    assign w_in_range = (32'(w_entry) < 32'(ENTRY_COUNT));
    assign w_in_xfer  = i_s_tvalid && o_s_tready;

    // state and registers
    t_state r_state, n_state;

    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_pv, n_pv;
    logic [EW-1:0]          r_pidx, n_pidx;
    logic [ENTRY_COUNT-1:0] r_in_use, n_in_use;
    logic [ENTRY_COUNT-1:0] r_busy, n_busy;
    logic [ENTRY_COUNT-1:0] r_valid, n_valid;
    logic [ENTRY_COUNT-1:0] r_dirty, n_dirty;
    logic                   r_out_valid, n_out_valid;

    logic [DEV_W-1:0]   r_dev, n_dev;
    logic [SEC_W-1:0]   r_sec, n_sec;
    logic               r_found, n_found;
    logic [EW-1:0]      r_hit, n_hit;
    logic [EW-1:0]      r_hit_rank, n_hit_rank;
    logic               r_any, n_any;
    logic [EW-1:0]      r_vic, n_vic;
    logic [EW-1:0]      r_vic_rank, n_vic_rank;
    logic [EW-1:0]      r_tgt, n_tgt;
    logic [EW-1:0]      r_old, n_old;
    logic [2:0]         r_res_status, n_res_status;
    logic [ENTRY_W-1:0] r_res_gent, n_res_gent;
    logic               r_res_fill, n_res_fill;
    logic               r_res_wb, n_res_wb;
    logic [15:0]        r_out_data, n_out_data;

    // memory ports
    logic             w_tag_we;
    logic [TAG_W-1:0] w_tag_q;
    logic             w_rank_we;
    logic [EW-1:0]    w_rank_waddr;
    logic [EW-1:0]    w_rank_wdata;
    logic [EW-1:0]    w_rank_q;
    logic [EW-1:0]    w_raddr;
    logic             w_issue;
    logic             w_out_free;

    assign w_raddr    = r_cnt[EW-1:0];
    assign w_out_free = !r_out_valid || i_m_tready;

    lrubc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRY_COUNT)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (r_vic),
        .i_wdata ({r_sec, r_dev}),
        .i_raddr (w_raddr),
        .o_rdata (w_tag_q)
    );

    lrubc_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRY_COUNT)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_rank_we),
        .i_waddr (w_rank_waddr),
        .i_wdata (w_rank_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rank_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == CNT_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_xfer) n_state = (w_cmd == CMD_ACQUIRE) ? S_WALK : S_HOLD;
            end
            S_WALK: begin
                if (r_cnt == CNT_END) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if ((r_found && !r_busy[r_hit]) || (!r_found && r_any)) n_state = S_RANK;
                else                                                   n_state = S_HOLD;
            end
            S_RANK: begin
                if (r_cnt == CNT_END) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // state decoded controls: handshake, memory reads and writes
    always_comb begin
        o_s_tready   = (r_state == S_IDLE);
        w_issue      = ((r_state == S_WALK) || (r_state == S_RANK)) && (r_cnt < CNT_END);
        w_tag_we     = (r_state == S_DECIDE) && !r_found && r_any;
        w_rank_we    = 1'b0;
        w_rank_waddr = r_pidx;
        w_rank_wdata = w_rank_q - EW'(1);
        case (r_state)
            S_CLEAR: begin
                w_rank_we    = 1'b1;
                w_rank_waddr = r_cnt[EW-1:0];
                w_rank_wdata = r_cnt[EW-1:0];
            end
            S_RANK: begin
                // chosen entry becomes newest, newer ones age by one
                if (r_pv) begin
                    if (r_pidx == r_tgt) begin
                        w_rank_we    = 1'b1;
                        w_rank_wdata = RANK_TOP;
                    end else if (w_rank_q > r_old) begin
                        w_rank_we    = 1'b1;
                    end
                end
            end
            default: begin
                w_rank_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_cnt        = r_cnt;
        n_pv         = w_issue;
        n_pidx       = r_cnt[EW-1:0];
        n_in_use     = r_in_use;
        n_busy       = r_busy;
        n_valid      = r_valid;
        n_dirty      = r_dirty;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_dev        = r_dev;
        n_sec        = r_sec;
        n_found      = r_found;
        n_hit        = r_hit;
        n_hit_rank   = r_hit_rank;
        n_any        = r_any;
        n_vic        = r_vic;
        n_vic_rank   = r_vic_rank;
        n_tgt        = r_tgt;
        n_old        = r_old;
        n_res_status = r_res_status;
        n_res_gent   = r_res_gent;
        n_res_fill   = r_res_fill;
        n_res_wb     = r_res_wb;
        n_out_data   = r_out_data;

        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + CW'(1);
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cnt        = '0;
                    n_dev        = w_dev;
                    n_sec        = w_sec;
                    n_found      = 1'b0;
                    n_any        = 1'b0;
                    n_res_status = ST_OK;
                    n_res_gent   = w_entry;
                    n_res_fill   = 1'b0;
                    n_res_wb     = 1'b0;
                    // flag-only commands finish here
                    if (w_cmd != CMD_ACQUIRE) begin
                        if (!w_in_range) begin
                            n_res_status = ST_NOT_OWNED;
                        end else if (w_cmd == CMD_SYNC_DONE) begin
                            n_valid[w_idx] = 1'b1;
                            n_dirty[w_idx] = 1'b0;
                        end else if (!r_busy[w_idx]) begin
                            n_res_status = ST_NOT_OWNED;
                        end else if (w_cmd == CMD_WRITEBACK) begin
                            n_dirty[w_idx] = 1'b1;
                            n_res_wb       = 1'b1;
                        end else begin
                            n_busy[w_idx] = 1'b0;
                        end
                    end
                end
            end
            S_WALK: begin
                if (r_cnt < CNT_END) n_cnt = r_cnt + CW'(1);
                if (r_pv) begin
                    // newest matching tag
                    if (r_in_use[r_pidx] && (w_tag_q == {r_sec, r_dev}) &&
                        (!r_found || (w_rank_q > r_hit_rank))) begin
                        n_found    = 1'b1;
                        n_hit      = r_pidx;
                        n_hit_rank = w_rank_q;
                    end
                    // oldest free entry
                    if (!r_busy[r_pidx] && (!r_any || (w_rank_q < r_vic_rank))) begin
                        n_any      = 1'b1;
                        n_vic      = r_pidx;
                        n_vic_rank = w_rank_q;
                    end
                end
            end
            S_DECIDE: begin
                n_cnt = '0;
                if (r_found) begin
                    n_res_gent = ENTRY_W'(r_hit);
                    if (r_busy[r_hit]) begin
                        n_res_status = ST_WAIT;
                    end else begin
                        n_res_status = ST_GRANTED;
                        n_res_fill   = !r_valid[r_hit];
                        n_busy[r_hit] = 1'b1;
                        n_tgt        = r_hit;
                        n_old        = r_hit_rank;
                    end
                end else if (r_any) begin
                    n_res_status   = ST_GRANTED;
                    n_res_gent     = ENTRY_W'(r_vic);
                    n_res_fill     = 1'b1;
                    n_in_use[r_vic] = 1'b1;
                    n_busy[r_vic]  = 1'b1;
                    n_valid[r_vic] = 1'b0;
                    n_dirty[r_vic] = 1'b0;
                    n_tgt          = r_vic;
                    n_old          = r_vic_rank;
                end else begin
                    n_res_status = ST_NO_FREE;
                    n_res_gent   = '0;
                end
            end
            S_RANK: begin
                if (r_cnt < CNT_END) n_cnt = r_cnt + CW'(1);
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'b0, r_res_wb, r_res_fill, r_res_gent, r_res_status};
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_in_use    <= '0;
            r_busy      <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pv        <= n_pv;
            r_in_use    <= n_in_use;
            r_busy      <= n_busy;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_dev        <= n_dev;
        r_sec        <= n_sec;
        r_found      <= n_found;
        r_hit        <= n_hit;
        r_hit_rank   <= n_hit_rank;
        r_any        <= n_any;
        r_vic        <= n_vic;
        r_vic_rank   <= n_vic_rank;
        r_tgt        <= n_tgt;
        r_old        <= n_old;
        r_res_status <= n_res_status;
        r_res_gent   <= n_res_gent;
        r_res_fill   <= n_res_fill;
        r_res_wb     <= n_res_wb;
        r_out_data   <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* rtl/lrubc_ram.sv */
// ----------------------------------------------------------------------------
// lrubc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lrubc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
